@@ rtl/abkf_pkg.sv @@
// ----------------------------------------------------------------------------
// Angle/bias Kalman filter package
// Sequencer state codes, step codes and configuration register indexes.
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int ANGLE_W = 25;
  localparam int RATE_W  = 28;
  localparam int DT_W    = 16;
  localparam int CFG_W   = 16;
  localparam int OUT_W   = 32;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [3:0] OP_ANGLE_PRED = 4'd0;
  localparam logic [3:0] OP_DP11       = 4'd1;
  localparam logic [3:0] OP_P00_PRED   = 4'd2;
  localparam logic [3:0] OP_P11_PRED   = 4'd3;
  localparam logic [3:0] OP_ANGLE_CORR = 4'd4;
  localparam logic [3:0] OP_BIAS_CORR  = 4'd5;
  localparam logic [3:0] OP_P00_CORR   = 4'd6;
  localparam logic [3:0] OP_P01_CORR   = 4'd7;
  localparam logic [3:0] OP_P10_CORR   = 4'd8;
  localparam logic [3:0] OP_P11_CORR   = 4'd9;

endpackage

@@ rtl/abkf_mul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial fixed-point multiplier
// Shift-and-add over one multiplier bit per cycle, then a saturating rescale.
// ----------------------------------------------------------------------------
module abkf_mul import abkf_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic                done,
  output logic signed [W-1:0] result
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  x_r, x_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic [W:0]    sum;
  logic [2*W-1:0] prod;
  logic [W-2:0]  val;
  logic          ovf;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    neg_nxt  = neg_r;
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, x_r} : '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      x_nxt    = mag(a);
      hi_nxt   = '0;
      lo_nxt   = mag(b);
      neg_nxt  = a[W-1] ^ b[W-1];
    end else if (busy_r) begin
      hi_nxt  = sum[W:1];
      lo_nxt  = {sum[0], lo_r[W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    prod = {hi_r, lo_r};
    ovf  = |prod[2*W-1:W-1+F];
    val  = prod[W-2+F:F];
    if (ovf) result = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else if (neg_r) result = -$signed({1'b0, val});
    else result = $signed({1'b0, val});
  end

  assign done = done_r;

endmodule

@@ rtl/abkf_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial fixed-point divider
// Restoring division, one quotient bit per cycle, with saturation and a zero result for a zero divisor.
// ----------------------------------------------------------------------------
module abkf_div import abkf_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] result
);

  localparam int N  = W + F;
  localparam int CW = $clog2(N + 1);

  logic          busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt, zero_r, zero_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [N-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  rem_r, rem_nxt, dm_r, dm_nxt;
  logic [W:0]    rs, diff;
  logic          ge, ovf;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dm_nxt   = dm_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    rs       = {rem_r, dvd_r[N-1]};
    diff     = rs - {1'b0, dm_r};
    ge       = rs >= {1'b0, dm_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(N);
      dvd_nxt  = {mag(num), {F{1'b0}}};
      rem_nxt  = '0;
      dm_nxt   = mag(den);
      neg_nxt  = num[W-1] ^ den[W-1];
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : rs[W-1:0];
      dvd_nxt = {dvd_r[N-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dm_r   <= dm_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    ovf = |dvd_r[N-1:W-1];
    if (zero_r) result = '0;
    else if (ovf) result = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else if (neg_r) result = -$signed({1'b0, dvd_r[W-2:0]});
    else result = $signed({1'b0, dvd_r[W-2:0]});
  end

  assign done = done_r;

endmodule

@@ rtl/angle_bias_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// Angle/bias Kalman filter
// One item at a time: the input stalls from acceptance until the result is loaded
// into the output register, and the next item can be accepted in the same cycle
// as the result appears. The multiply steps share one bit-serial multiplier and
// the divide steps share one bit-serial divider.
// Reset clears the estimates and covariance and loads the default noise values.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter import abkf_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_measured_angle,
  input  logic signed [RATE_W-1:0]  in_measured_rate,
  input  logic [DT_W-1:0]           in_time_step,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_filtered_angle
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int UP = (F >= 16) ? F - 16 : 0;
  localparam int DN = (F >= 16) ? 0 : 16 - F;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sadd = s[W] ? SMIN : SMAX;
    else sadd = s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) ssub = s[W] ? SMIN : SMAX;
    else ssub = s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] rsc_in(input logic signed [31:0] v);
    logic [31:0] m;
    logic [63:0] sh;
    m  = v[31] ? (~v + 1'b1) : v;
    sh = ({32'b0, m} << UP) >> DN;
    if ((sh >> (W - 1)) != 64'd0) rsc_in = v[31] ? SMIN : SMAX;
    else if (v[31]) rsc_in = -$signed(sh[W-1:0]);
    else rsc_in = $signed(sh[W-1:0]);
  endfunction

  function automatic logic signed [OUT_W-1:0] rsc_out(input logic signed [W-1:0] v);
    logic [W-1:0] m;
    logic [63:0]  sh;
    m  = v[W-1] ? (~v + 1'b1) : v;
    sh = (64'(m) << DN) >> UP;
    if ((sh >> 31) != 64'd0) rsc_out = v[W-1] ? 32'sh80000000 : 32'sh7fffffff;
    else if (v[W-1]) rsc_out = -$signed(sh[31:0]);
    else rsc_out = $signed(sh[31:0]);
  endfunction

  logic [CFG_W-1:0]   qa_cfg_r, qb_cfg_r, rm_cfg_r;
  logic [1:0]         state_r, state_nxt;
  logic [3:0]         op_r, op_nxt;
  logic               issued_r, issued_nxt, dsel_r, dsel_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_angle_r, out_angle_nxt;
  logic signed [W-1:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [W-1:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [W-1:0] mang_r, mang_nxt, mrate_r, mrate_nxt, dt_r, dt_nxt;
  logic signed [W-1:0] dp11_r, dp11_nxt, t_r, t_nxt, y_r, y_nxt, s_r, s_nxt;
  logic signed [W-1:0] p00s_r, p00s_nxt, p01s_r, p01s_nxt;
  logic signed [W-1:0] k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [W-1:0] qa, qb, rm, ma, mb, mres, dnum, dres;
  logic               mstart, mdone, dstart, ddone, in_acc;

  assign qa = rsc_in({16'b0, qa_cfg_r});
  assign qb = rsc_in({16'b0, qb_cfg_r});
  assign rm = rsc_in({16'b0, rm_cfg_r});

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    case (op_r)
      OP_ANGLE_PRED: begin ma = dt_r; mb = ssub(mrate_r, bias_r); end
      OP_DP11:       begin ma = dt_r; mb = p11_r; end
      OP_P00_PRED:   begin ma = dt_r; mb = t_r; end
      OP_P11_PRED:   begin ma = qb;   mb = dt_r; end
      OP_ANGLE_CORR: begin ma = k0_r; mb = y_r; end
      OP_BIAS_CORR:  begin ma = k1_r; mb = y_r; end
      OP_P00_CORR:   begin ma = k0_r; mb = p00s_r; end
      OP_P01_CORR:   begin ma = k0_r; mb = p01s_r; end
      OP_P10_CORR:   begin ma = k1_r; mb = p00s_r; end
      default:       begin ma = k1_r; mb = p01s_r; end
    endcase
  end

  assign mstart = (state_r == S_MUL) && !issued_r;
  assign dstart = (state_r == S_DIV) && !issued_r;
  assign dnum   = dsel_r ? p10_r : p00_r;

  abkf_mul #(.W(W), .F(F)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
    .done(mdone), .result(mres)
  );

  abkf_div #(.W(W), .F(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(s_r),
    .done(ddone), .result(dres)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    issued_nxt    = issued_r;
    dsel_nxt      = dsel_r;
    out_valid_nxt = out_valid_r;
    out_angle_nxt = out_angle_r;
    ang_nxt  = ang_r;  bias_nxt = bias_r;
    p00_nxt  = p00_r;  p01_nxt  = p01_r;  p10_nxt = p10_r;  p11_nxt = p11_r;
    mang_nxt = mang_r; mrate_nxt = mrate_r; dt_nxt = dt_r;
    dp11_nxt = dp11_r; t_nxt = t_r; y_nxt = y_r; s_nxt = s_r;
    p00s_nxt = p00s_r; p01s_nxt = p01s_r; k0_nxt = k0_r; k1_nxt = k1_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mang_nxt   = rsc_in(32'(in_measured_angle));
          mrate_nxt  = rsc_in(32'(in_measured_rate));
          dt_nxt     = rsc_in({16'b0, in_time_step});
          op_nxt     = OP_ANGLE_PRED;
          issued_nxt = 1'b0;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (mdone) begin
          issued_nxt = 1'b0;
          op_nxt     = op_r + 1'b1;
          case (op_r)
            OP_ANGLE_PRED: ang_nxt = sadd(ang_r, mres);
            OP_DP11: begin
              dp11_nxt = mres;
              t_nxt    = sadd(ssub(ssub(mres, p01_r), p10_r), qa);
            end
            OP_P00_PRED: begin
              p00_nxt = sadd(p00_r, mres);
              p01_nxt = ssub(p01_r, dp11_r);
              p10_nxt = ssub(p10_r, dp11_r);
            end
            OP_P11_PRED: begin
              p11_nxt   = sadd(p11_r, mres);
              y_nxt     = ssub(mang_r, ang_r);
              s_nxt     = sadd(p00_r, rm);
              p00s_nxt  = p00_r;
              p01s_nxt  = p01_r;
              dsel_nxt  = 1'b0;
              state_nxt = S_DIV;
            end
            OP_ANGLE_CORR: ang_nxt  = sadd(ang_r, mres);
            OP_BIAS_CORR:  bias_nxt = sadd(bias_r, mres);
            OP_P00_CORR:   p00_nxt  = ssub(p00_r, mres);
            OP_P01_CORR:   p01_nxt  = ssub(p01_r, mres);
            OP_P10_CORR:   p10_nxt  = ssub(p10_r, mres);
            default: begin
              p11_nxt   = ssub(p11_r, mres);
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_DIV: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (ddone) begin
          issued_nxt = 1'b0;
          if (!dsel_r) begin
            k0_nxt   = dres;
            dsel_nxt = 1'b1;
          end else begin
            k1_nxt    = dres;
            op_nxt    = OP_ANGLE_CORR;
            state_nxt = S_MUL;
          end
        end
      end
      default: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = rsc_out(ang_r);
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_cfg_r    <= CFG_W'(66);
      qb_cfg_r    <= CFG_W'(197);
      rm_cfg_r    <= CFG_W'(1966);
      state_r     <= S_IDLE;
      op_r        <= OP_ANGLE_PRED;
      issued_r    <= 1'b0;
      dsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ang_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_NOISE: qa_cfg_r <= cfg_wdata;
          REG_BIAS_NOISE:  qb_cfg_r <= cfg_wdata;
          REG_MEAS_NOISE:  rm_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      issued_r    <= issued_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r <= ang_nxt; bias_r <= bias_nxt;
      p00_r <= p00_nxt; p01_r <= p01_nxt; p10_r <= p10_nxt; p11_r <= p11_nxt;
    end
    out_angle_r <= out_angle_nxt;
    mang_r <= mang_nxt; mrate_r <= mrate_nxt; dt_r <= dt_nxt;
    dp11_r <= dp11_nxt; t_r <= t_nxt; y_r <= y_nxt; s_r <= s_nxt;
    p00s_r <= p00s_nxt; p01s_r <= p01s_nxt; k0_r <= k0_nxt; k1_r <= k1_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_angle_r;

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mdone |-> (state_r == S_MUL) && issued_r)
    else $error("multiplier finished outside a multiply step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> (state_r == S_DIV) && issued_r)
    else $error("divider finished outside a divide step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MUL) && (op_r == OP_ANGLE_PRED) && !issued_r)
    else $error("accepted item did not start the prediction");

  a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (op_r == OP_P11_CORR + 4'd1))
    else $error("result stage reached before the last covariance update");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Angle/bias Kalman filter testbench
// Drives filter steps through the valid/stall input channel and runs the noise
// registers through several settings, the extremes among them. A scoreboard
// predicts every filtered angle in fixed point and checks results in order.
// ----------------------------------------------------------------------------
class angle_scoreboard;
  localparam longint MAXV = 64'sh7FFF_FFFF;
  localparam longint MINV = -64'sh8000_0000;

  longint angle_est, bias_est;
  longint cov [4];
  longint q_angle, q_bias, r_meas;
  longint angle_q [$];
  int mismatches, checked, noted;

  function new();
    angle_est = 0;
    bias_est = 0;
    foreach (cov[i]) cov[i] = 0;
    q_angle = 66;
    q_bias = 197;
    r_meas = 1966;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      abkf_pkg::REG_ANGLE_NOISE: q_angle = val;
      abkf_pkg::REG_BIAS_NOISE: q_bias = val;
      abkf_pkg::REG_MEAS_NOISE: r_meas = val;
      default: ;
    endcase
  endfunction

  function longint clamp(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function longint signed_from_mag(bit neg, longint unsigned m);
    if (!neg) return (m > MAXV) ? MAXV : longint'(m);
    if (m > MAXV + 1) return MINV;
    return -longint'(m);
  endfunction

  function longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = mag(a) * mag(b);
    return signed_from_mag((a < 0) != (b < 0), p >> 16);
  endfunction

  function longint fx_div(longint n, longint d);
    longint unsigned dm;
    dm = mag(d);
    if (dm == 0) return 0;
    return signed_from_mag((n < 0) != (d < 0), (mag(n) << 16) / dm);
  endfunction

  function void note_input(longint m_angle, longint m_rate, longint dt);
    longint rate, t, dp11, y, s, k0, k1, p00, p01;
    rate = clamp(m_rate - bias_est);
    angle_est = clamp(angle_est + fx_mul(dt, rate));
    dp11 = fx_mul(dt, cov[3]);
    t = clamp(dp11 - cov[1]);
    t = clamp(t - cov[2]);
    t = clamp(t + q_angle);
    cov[0] = clamp(cov[0] + fx_mul(dt, t));
    cov[1] = clamp(cov[1] - dp11);
    cov[2] = clamp(cov[2] - dp11);
    cov[3] = clamp(cov[3] + fx_mul(q_bias, dt));
    y = clamp(m_angle - angle_est);
    s = clamp(cov[0] + r_meas);
    k0 = fx_div(cov[0], s);
    k1 = fx_div(cov[2], s);
    angle_est = clamp(angle_est + fx_mul(k0, y));
    bias_est = clamp(bias_est + fx_mul(k1, y));
    p00 = cov[0];
    p01 = cov[1];
    cov[0] = clamp(cov[0] - fx_mul(k0, p00));
    cov[1] = clamp(cov[1] - fx_mul(k0, p01));
    cov[2] = clamp(cov[2] - fx_mul(k1, p00));
    cov[3] = clamp(cov[3] - fx_mul(k1, p01));
    angle_q.push_back(angle_est);
    noted++;
  endfunction

  function void check_result(logic signed [31:0] got);
    longint exp_angle;
    checked++;
    if (angle_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %0d", got);
      return;
    end
    exp_angle = angle_q.pop_front();
    if (longint'(got) != exp_angle) begin
      mismatches++;
      if (mismatches <= 10)
        $display("filtered_angle mismatch: expected %0d, got %0d", exp_angle, got);
    end
  endfunction
endclass

module tb_top;
  import abkf_pkg::*;

  localparam longint LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [ANGLE_W-1:0] in_measured_angle;
  logic signed [RATE_W-1:0] in_measured_rate;
  logic [DT_W-1:0] in_time_step;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] out_filtered_angle;

  angle_scoreboard sb;
  bit quiet;
  longint cycles;
  int cfg_writes;

  angle_bias_kalman_filter dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 16);
    if (rst_n && in_valid && !in_stall)
      sb.note_input(in_measured_angle, in_measured_rate, in_time_step);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_filtered_angle);
  end

  task automatic send_item(logic signed [ANGLE_W-1:0] a, logic signed [RATE_W-1:0] r,
                           logic [DT_W-1:0] dt);
    int gap;
    gap = (!quiet && $urandom_range(99) < 16) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measured_angle <= a;
    in_measured_rate <= r;
    in_time_step <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.angle_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_noise(logic [15:0] qa, logic [15:0] qb, logic [15:0] rm);
    logic [15:0] vals [3];
    vals = '{qa, qb, rm};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      sb.write_reg(2'(i), vals[i]);
      @(posedge clk);
      cfg_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n);
    logic signed [ANGLE_W-1:0] a;
    logic signed [RATE_W-1:0] r;
    logic [DT_W-1:0] dt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        a = ANGLE_W'($signed($urandom_range(0, 23592960)) - 11796480);
        r = RATE_W'($signed($urandom_range(0, 262144000)) - 131072000);
        dt = DT_W'($urandom_range(1, 1500));
      end else begin
        a = ANGLE_W'($urandom);
        r = RATE_W'($urandom);
        dt = DT_W'($urandom);
      end
      send_item(a, r, dt);
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    cycles = 0;
    cfg_writes = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ANGLE_NOISE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_measured_angle = '0;
    in_measured_rate = '0;
    in_time_step = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(25'sd11796480, 28'sd131072000, 16'd65535);
    send_item(-25'sd11796480, -28'sd131072000, 16'd1);
    send_item(25'sh0FFFFFF, 28'sh7FFFFFF, 16'd65535);
    send_item(25'sh1000000, 28'sh8000000, 16'd65535);
    send_item(25'sd0, 28'sd0, 16'd0);
    send_item(25'sd65536, 28'sd655360, 16'd66);
    send_item(-25'sd65536, -28'sd655360, 16'd655);
    drain();
    set_noise(16'd0, 16'd0, 16'd0);
    send_item(25'sd0, 28'sd0, 16'd0);
    send_item(25'sd1000, 28'sd5000, 16'd0);
    send_item(-25'sd327680, 28'sd65536, 16'd100);
    send_item(25'sd11796480, -28'sd131072000, 16'd65535);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_wdata <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_noise(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(25'sd11796480, 28'sd131072000, 16'd65535);
    send_item(-25'sd11796480, -28'sd131072000, 16'd65535);
    send_item(25'sd5, -28'sd7, 16'd1);
    drain();
    set_noise(16'd66, 16'd197, 16'd1966);
    random_items(120);
    quiet = 1;
    random_items(60);
    quiet = 0;
    drain();
    set_noise(16'd0, 16'hFFFF, 16'd1);
    random_items(70);
    drain();
    set_noise(16'hFFFF, 16'd0, 16'hFFFF);
    random_items(70);
    drain();
    set_noise(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
    random_items(110);
    drain();
    repeat (500) @(posedge clk);

    $display("Ran %0d filter steps and checked %0d results over %0d register writes,",
             sb.noted, sb.checked, cfg_writes);
    $display("covering extreme inputs, zero and full-scale noise, and random stalls.");
    if (sb.mismatches == 0 && sb.angle_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.angle_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
